// ===== rtl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Noise synthesis pixel package
// Shared constants, types and helpers for the pixel noise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

	localparam int CURVE_POINTS = 8;
	localparam int SEG_COUNT = CURVE_POINTS - 2;
	localparam int REG_POINTS = 8;
	localparam int POINT_W = 10;
	localparam int IDX_W = 3;
	localparam int FRAC_BITS = 14;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 2;
	localparam int MIX_W = 23;
	localparam int STR_W = 25;
	localparam int PROD_W = 48;
	localparam int NOISE_W = 22;
	localparam int NORM_Q16 = 14418;

	localparam logic [STR_W-1:0] STRENGTH_ONE = STR_W'(1 << 24);

	localparam logic [CFG_IDX_W-1:0] REG_LUT_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LUT_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YTOX = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YTOB = 2'd3;

	typedef logic [POINT_W-1:0] point_t;
	typedef point_t [REG_POINTS-1:0] point_set_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] b;
	} pix_t;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [41:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 42'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -42'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nsp_strength.sv =====
// ----------------------------------------------------------------------------
// Noise strength lookup
// Two pipeline stages: intensity scaling and segment selection, then linear
// interpolation between curve points with a clamp to [0,1].
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_strength (
	input  wire logic                            clk,
	input  wire logic signed [16:0]              sum2,
	input  wire nsp_pkg::point_set_t             points,
	output logic        [nsp_pkg::STR_W-1:0]     strength_s2
);

	logic signed [19:0] scaled;
	logic        [18:0] pos;
	logic        [4:0]  idx_raw;
	logic        [nsp_pkg::IDX_W-1:0] idx;
	logic        [18:0] frac;

	logic [nsp_pkg::IDX_W-1:0] idx_s1;
	logic [18:0]               frac_s1;

	nsp_pkg::point_t    lo;
	nsp_pkg::point_t    hi;
	logic signed [10:0] diff;
	logic signed [30:0] val;
	logic [nsp_pkg::STR_W-1:0] str_c;

	assign scaled  = 20'(sum2) * 20'(nsp_pkg::SEG_COUNT);
	assign pos     = scaled[19] ? '0 : scaled[18:0];
	assign idx_raw = pos[18:nsp_pkg::FRAC_BITS];
	assign idx     = (idx_raw > 5'(nsp_pkg::SEG_COUNT)) ? nsp_pkg::IDX_W'(nsp_pkg::SEG_COUNT)
	                                                   : idx_raw[nsp_pkg::IDX_W-1:0];
	assign frac    = pos - 19'({idx, 14'b0});

	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		frac_s1 <= frac;
	end

	assign lo   = points[idx_s1];
	assign hi   = points[idx_s1 + nsp_pkg::IDX_W'(1)];
	assign diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign val  = diff * $signed({1'b0, frac_s1}) + $signed({7'b0, lo, 14'b0});

	always_comb begin
		if (val[30]) begin
			str_c = '0;
		end else if (val > $signed({6'b0, nsp_pkg::STRENGTH_ONE})) begin
			str_c = nsp_pkg::STRENGTH_ONE;
		end else begin
			str_c = val[nsp_pkg::STR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		strength_s2 <= str_c;
	end

endmodule

`default_nettype wire

// ===== rtl/noise_synthesis_pixel.sv =====
// ----------------------------------------------------------------------------
// Noise synthesis pixel
// Adds intensity-shaped noise to one X, Y, B pixel per clock.
// ----------------------------------------------------------------------------
// A request is issued by holding start high with the six sample and noise
// fields on their ports; busy is always low, so a request is taken at every
// rising edge at which start is high, one per cycle with no gaps.
// The result appears on out_x, out_y and out_b for one cycle, marked by
// done, after the six register stages below. Results leave in request order.
// The six register stages are: intensity scaling and segment choice, curve
// interpolation, noise mix times strength, times the 0.22 scale with
// rounding, chroma-from-luma products, and the final round and saturate.
// The receiver cannot hold results off, so no stage ever stalls.
// Configuration is written through cfg_we, cfg_idx and cfg_data: index 0 is
// the low curve points, 1 the high curve points, 2 ytox and 3 ytob. Writes
// take effect at once and should be made while no request is in flight.
// Reset clears the configuration to zero and empties the pipeline.
`default_nettype none

module noise_synthesis_pixel (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [nsp_pkg::SAMPLE_W-1:0]    opsin_x,
	input  wire logic signed [nsp_pkg::SAMPLE_W-1:0]    opsin_y,
	input  wire logic signed [nsp_pkg::SAMPLE_W-1:0]    opsin_b,
	input  wire logic signed [nsp_pkg::SAMPLE_W-1:0]    noise_r,
	input  wire logic signed [nsp_pkg::SAMPLE_W-1:0]    noise_g,
	input  wire logic signed [nsp_pkg::SAMPLE_W-1:0]    noise_c,
	output logic                                        done,
	output logic signed [nsp_pkg::SAMPLE_W-1:0]         out_x,
	output logic signed [nsp_pkg::SAMPLE_W-1:0]         out_y,
	output logic signed [nsp_pkg::SAMPLE_W-1:0]         out_b,
	input  wire logic                                   cfg_we,
	input  wire logic [nsp_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  wire logic [nsp_pkg::CFG_W-1:0]              cfg_data
);

	logic [nsp_pkg::CFG_W-1:0] lut_lo_q;
	logic [nsp_pkg::CFG_W-1:0] lut_hi_q;
	logic signed [15:0]        ytox_q;
	logic signed [15:0]        ytob_q;
	nsp_pkg::point_set_t       points;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	nsp_pkg::pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;

	logic signed [16:0] sum2_g;
	logic signed [16:0] sum2_r;
	logic signed [nsp_pkg::MIX_W-1:0] mix_r;
	logic signed [nsp_pkg::MIX_W-1:0] mix_g;
	logic signed [nsp_pkg::MIX_W-1:0] mix_r_s1, mix_g_s1, mix_r_s2, mix_g_s2;
	logic [nsp_pkg::STR_W-1:0] str_r_s2;
	logic [nsp_pkg::STR_W-1:0] str_g_s2;

	logic signed [nsp_pkg::PROD_W-1:0] prod_r_s3, prod_g_s3;
	logic signed [62:0] scl_r;
	logic signed [62:0] scl_g;
	logic signed [nsp_pkg::NOISE_W-1:0] rn_s4, gn_s4;

	logic signed [22:0] nsum;
	logic signed [22:0] sum_s5, diff_s5;
	logic signed [38:0] xprod_s5, bprod_s5;

	logic signed [40:0] acc_x;
	logic signed [40:0] acc_b;
	logic signed [25:0] acc_y;
	logic signed [40:0] rnd_x;
	logic signed [40:0] rnd_b;
	logic signed [25:0] rnd_y;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_lo_q <= '0;
			lut_hi_q <= '0;
			ytox_q   <= '0;
			ytob_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				nsp_pkg::REG_LUT_LO: lut_lo_q <= cfg_data;
				nsp_pkg::REG_LUT_HI: lut_hi_q <= cfg_data;
				nsp_pkg::REG_YTOX:   ytox_q   <= cfg_data[15:0];
				nsp_pkg::REG_YTOB:   ytob_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			points[i]     = lut_lo_q[i*nsp_pkg::POINT_W +: nsp_pkg::POINT_W];
			points[i + 4] = lut_hi_q[i*nsp_pkg::POINT_W +: nsp_pkg::POINT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign sum2_g = 17'(opsin_y) - 17'(opsin_x);
	assign sum2_r = 17'(opsin_y) + 17'(opsin_x);

	nsp_strength u_str_g (
		.clk         (clk),
		.sum2        (sum2_g),
		.points      (points),
		.strength_s2 (str_g_s2)
	);

	nsp_strength u_str_r (
		.clk         (clk),
		.sum2        (sum2_r),
		.points      (points),
		.strength_s2 (str_r_s2)
	);

	assign mix_r = 23'(noise_r) + (23'(noise_c) <<< 7) - 23'(noise_c);
	assign mix_g = 23'(noise_g) + (23'(noise_c) <<< 7) - 23'(noise_c);

	always_ff @(posedge clk) begin
		pix_s1.x <= opsin_x;
		pix_s1.y <= opsin_y;
		pix_s1.b <= opsin_b;
		mix_r_s1 <= mix_r;
		mix_g_s1 <= mix_g;
		pix_s2   <= pix_s1;
		mix_r_s2 <= mix_r_s1;
		mix_g_s2 <= mix_g_s1;
	end

	always_ff @(posedge clk) begin
		pix_s3    <= pix_s2;
		prod_r_s3 <= $signed(mix_r_s2) * $signed({1'b0, str_r_s2});
		prod_g_s3 <= $signed(mix_g_s2) * $signed({1'b0, str_g_s2});
	end

	assign scl_r = 63'(prod_r_s3) * 63'(nsp_pkg::NORM_Q16) + 63'(64'sd1 <<< 39);
	assign scl_g = 63'(prod_g_s3) * 63'(nsp_pkg::NORM_Q16) + 63'(64'sd1 <<< 39);

	always_ff @(posedge clk) begin
		pix_s4 <= pix_s3;
		rn_s4  <= scl_r[61:40];
		gn_s4  <= scl_g[61:40];
	end

	assign nsum = 23'(rn_s4) + 23'(gn_s4);

	always_ff @(posedge clk) begin
		pix_s5   <= pix_s4;
		sum_s5   <= nsum;
		diff_s5  <= 23'(rn_s4) - 23'(gn_s4);
		xprod_s5 <= 39'(ytox_q) * 39'(nsum);
		bprod_s5 <= 39'(ytob_q) * 39'(nsum);
	end

	assign acc_x = (41'(pix_s5.x) <<< 19) + (41'(diff_s5) <<< 12) + 41'(xprod_s5)
	             + 41'sd262144;
	assign acc_b = (41'(pix_s5.b) <<< 19) + 41'(bprod_s5) + 41'sd262144;
	assign acc_y = (26'(pix_s5.y) <<< 7) + 26'(sum_s5) + 26'sd64;
	assign rnd_x = acc_x >>> 19;
	assign rnd_b = acc_b >>> 19;
	assign rnd_y = acc_y >>> 7;

	always_ff @(posedge clk) begin
		out_x <= nsp_pkg::sat16(42'(rnd_x));
		out_y <= nsp_pkg::sat16(42'(rnd_y));
		out_b <= nsp_pkg::sat16(42'(rnd_b));
	end

	assign done = v_s6;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("request did not produce a result after six cycles");

	a_str_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (str_r_s2 <= nsp_pkg::STRENGTH_ONE) && (str_g_s2 <= nsp_pkg::STRENGTH_ONE))
		else $error("noise strength above one");

	a_zero_curve: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && $past(lut_lo_q == '0 && lut_hi_q == '0) |-> str_r_s2 == '0 && str_g_s2 == '0)
		else $error("nonzero strength from an all-zero curve");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Noise synthesis pixel testbench
// Drives pixel requests with random gaps through a queue-fed driver, predicts
// each noisy X, Y, B result from the programmed strength curve and the
// chroma-from-luma factors, and checks every result in request order across
// several curve settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_PHASES = 8;
	localparam int PIXELS_PER_PHASE = 175;
	localparam int SW = nsp_pkg::SAMPLE_W;
	localparam int CW = nsp_pkg::CFG_W;
	localparam longint STRENGTH_FULL = longint'(1) <<< 24;
	localparam logic signed [SW-1:0] S_MAX = 16'sh7fff;
	localparam logic signed [SW-1:0] S_MIN = 16'sh8000;

	typedef struct {
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic signed [SW-1:0] b;
		logic signed [SW-1:0] nr;
		logic signed [SW-1:0] ng;
		logic signed [SW-1:0] nc;
		int unsigned gap;
	} pixel_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [SW-1:0] opsin_x = '0;
	logic signed [SW-1:0] opsin_y = '0;
	logic signed [SW-1:0] opsin_b = '0;
	logic signed [SW-1:0] noise_r = '0;
	logic signed [SW-1:0] noise_g = '0;
	logic signed [SW-1:0] noise_c = '0;
	logic done;
	logic signed [SW-1:0] out_x;
	logic signed [SW-1:0] out_y;
	logic signed [SW-1:0] out_b;
	logic cfg_we = 1'b0;
	logic [nsp_pkg::CFG_IDX_W-1:0] cfg_idx = nsp_pkg::REG_LUT_LO;
	logic [CW-1:0] cfg_data = '0;

	logic [CW-1:0] curve_lo = '0;
	logic [CW-1:0] curve_hi = '0;
	longint ytox_gain = 0;
	longint ytob_gain = 0;

	pixel_req_t pending_pixels[$];
	nsp_pkg::pix_t expected_pixels[$];
	pixel_req_t next_pixel;
	logic holding = 1'b0;
	int unsigned gap_left = 0;
	int unsigned requests_issued = 0;
	int unsigned requests_taken = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;

	noise_synthesis_pixel dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.opsin_x,
		.opsin_y,
		.opsin_b,
		.noise_r,
		.noise_g,
		.noise_c,
		.done,
		.out_x,
		.out_y,
		.out_b,
		.cfg_we,
		.cfg_idx,
		.cfg_data
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint round_half_up(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [SW-1:0] clamp_sample(input longint v);
		if (v > 32767) begin
			return S_MAX;
		end else if (v < -32768) begin
			return S_MIN;
		end
		return SW'(v);
	endfunction

	function automatic longint curve_point(input longint seg);
		logic [CW-1:0] word;
		longint p;
		word = (seg < 4) ? curve_lo : curve_hi;
		p = (word >> (nsp_pkg::POINT_W * (seg % 4))) & 40'h3ff;
		return p;
	endfunction

	// Strength in units of 2^-24 for twice the intensity in sample units.
	function automatic longint curve_strength(input longint twice_intensity);
		longint s, seg, frac, lo, hi, val;
		s = twice_intensity * nsp_pkg::SEG_COUNT;
		if (s < 0) begin
			s = 0;
		end
		seg = s >>> nsp_pkg::FRAC_BITS;
		if (seg > nsp_pkg::SEG_COUNT) begin
			seg = nsp_pkg::SEG_COUNT;
		end
		frac = s - (seg <<< nsp_pkg::FRAC_BITS);
		lo = curve_point(seg);
		hi = curve_point(seg + 1);
		val = lo * (longint'(1) <<< nsp_pkg::FRAC_BITS) + (hi - lo) * frac;
		if (val < 0) begin
			val = 0;
		end
		if (val > STRENGTH_FULL) begin
			val = STRENGTH_FULL;
		end
		return val;
	endfunction

	function automatic nsp_pkg::pix_t predict_noisy_pixel(input logic signed [SW-1:0] x, y, b,
			nr, ng, nc);
		longint xs, ys, bs, rs, gs, cs;
		longint st_g, st_r, mix_r, mix_g, rn, gn, sum, dx, db;
		nsp_pkg::pix_t res;
		xs = x;
		ys = y;
		bs = b;
		rs = nr;
		gs = ng;
		cs = nc;
		st_g = curve_strength(ys - xs);
		st_r = curve_strength(ys + xs);
		mix_r = (rs + 127 * cs) * nsp_pkg::NORM_Q16;
		mix_g = (gs + 127 * cs) * nsp_pkg::NORM_Q16;
		rn = round_half_up(mix_r * st_r, 40);
		gn = round_half_up(mix_g * st_g, 40);
		sum = rn + gn;
		dx = (rn - gn) * 4096 + ytox_gain * sum;
		db = ytob_gain * sum;
		res.x = clamp_sample(round_half_up((xs <<< 19) + dx, 19));
		res.y = clamp_sample(round_half_up((ys <<< 7) + sum, 7));
		res.b = clamp_sample(round_half_up((bs <<< 19) + db, 19));
		return res;
	endfunction

	function automatic logic [CW-1:0] pack_points(
			input logic [nsp_pkg::POINT_W-1:0] p0, p1, p2, p3);
		return {p3, p2, p1, p0};
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: begin
				return S_MAX;
			end
			1: begin
				return S_MIN;
			end
			2, 3: begin
				return SW'($urandom);
			end
			default: begin
				return SW'(int'($urandom_range(0, 24575)) - 12288);
			end
		endcase
	endfunction

	function automatic logic signed [SW-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: begin
				return S_MAX;
			end
			1: begin
				return S_MIN;
			end
			2: begin
				return SW'($urandom);
			end
			default: begin
				return SW'(int'($urandom_range(0, 16383)) - 8192);
			end
		endcase
	endfunction

	task automatic queue_pixel(input logic signed [SW-1:0] x, y, b, nr, ng, nc,
			input int unsigned gap);
		pixel_req_t p;
		p.x = x;
		p.y = y;
		p.b = b;
		p.nr = nr;
		p.ng = ng;
		p.nc = nc;
		p.gap = gap;
		pending_pixels.insert(pending_pixels.size(), p);
	endtask

	task automatic await_idle();
		while (pending_pixels.size() != 0 || holding || start || expected_pixels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic program_curve(input logic [CW-1:0] lo, hi,
			input logic signed [SW-1:0] xf, bf);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= nsp_pkg::REG_LUT_LO;
		cfg_data <= lo;
		@(negedge clk);
		cfg_idx <= nsp_pkg::REG_LUT_HI;
		cfg_data <= hi;
		@(negedge clk);
		cfg_idx <= nsp_pkg::REG_YTOX;
		cfg_data <= {{(CW - SW){xf[SW-1]}}, xf};
		@(negedge clk);
		cfg_idx <= nsp_pkg::REG_YTOB;
		cfg_data <= {{(CW - SW){bf[SW-1]}}, bf};
		@(negedge clk);
		cfg_we <= 1'b0;
		curve_lo = lo;
		curve_hi = hi;
		ytox_gain = xf;
		ytob_gain = bf;
	endtask

	always @(negedge clk) begin
		if (!start || requests_taken == requests_issued) begin
			if (!holding && pending_pixels.size() != 0) begin
				next_pixel = pending_pixels.pop_front();
				holding = 1'b1;
				gap_left = next_pixel.gap;
			end
			if (holding && gap_left == 0) begin
				opsin_x <= next_pixel.x;
				opsin_y <= next_pixel.y;
				opsin_b <= next_pixel.b;
				noise_r <= next_pixel.nr;
				noise_g <= next_pixel.ng;
				noise_c <= next_pixel.nc;
				start <= 1'b1;
				requests_issued++;
				holding = 1'b0;
			end else begin
				start <= 1'b0;
				if (holding) begin
					gap_left--;
				end
			end
		end
	end

	always @(posedge clk) begin
		nsp_pkg::pix_t got, want;
		if ((arst_n && start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (arst_n) begin
			if (start && !busy) begin
				expected_pixels.insert(expected_pixels.size(),
					predict_noisy_pixel(opsin_x, opsin_y, opsin_b, noise_r, noise_g, noise_c));
				requests_taken++;
			end
			if (done) begin
				got.x = out_x;
				got.y = out_y;
				got.b = out_b;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Result x=%0d y=%0d b=%0d arrived with no request outstanding.",
							got.x, got.y, got.b);
					end
				end else begin
					want = expected_pixels.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.b !== want.b) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: expected x=%0d y=%0d b=%0d, got x=%0d y=%0d b=%0d.",
								want.x, want.y, want.b, got.x, got.y, got.b);
						end
					end
				end
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic burst;
		logic [CW-1:0] lo, hi;
		logic signed [SW-1:0] xf, bf;
		burst = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With the reset curve all strengths are zero, so samples pass through.
		queue_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
		queue_pixel(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1);
		queue_pixel(16'sd1234, -16'sd4321, 16'sd777, 16'sd9000, -16'sd9000, 16'sd5000, 0);
		await_idle();

		// A rising last segment extrapolates past full strength.
		program_curve(pack_points(0, 200, 400, 600), pack_points(800, 900, 950, 1023),
			16'sh1000, 16'shf800);
		queue_pixel(16'sd0, 16'sd0, 16'sd0, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(16'sd8192, -16'sd8192, 16'sd100, S_MAX, S_MIN, 16'sd4000, 0);
		queue_pixel(16'sd0, 16'sd4096, 16'sd0, 16'sd3000, 16'sd3000, 16'sd3000, 0);
		queue_pixel(16'sd4096, 16'sd4096, 16'sd0, -16'sd5000, 16'sd2000, -16'sd3000, 2);
		queue_pixel(16'sd0, 16'sd16384, 16'sd0, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(16'sd0, S_MAX, 16'sd0, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(S_MIN, S_MAX, 16'sd0, S_MIN, S_MIN, S_MIN, 0);
		queue_pixel(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(16'sd0, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 3);
		queue_pixel(16'sd0, 16'sd12000, S_MAX, S_MAX, 16'sd0, 16'sd0, 0);
		queue_pixel(16'sd0, 16'sd12000, S_MIN, 16'sd0, S_MIN, 16'sd0, 0);
		queue_pixel(-16'sd2000, 16'sd6000, 16'sd500, S_MIN, S_MAX, S_MIN, 0);
		await_idle();

		// A falling last segment extrapolates below zero strength.
		program_curve(pack_points(1023, 1023, 600, 300), pack_points(100, 50, 1023, 0),
			S_MIN, S_MAX);
		queue_pixel(16'sd0, S_MAX, 16'sd0, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(16'sd0, 16'sd16000, 16'sd0, S_MAX, S_MAX, S_MAX, 0);
		queue_pixel(S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, 0);
		queue_pixel(S_MIN, 16'sd0, S_MIN, S_MAX, S_MIN, S_MAX, 0);
		queue_pixel(16'sd1000, 16'sd1500, -16'sd1500, S_MAX, S_MAX, S_MAX, 1);
		await_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					lo = '1;
					hi = '1;
					xf = S_MAX;
					bf = S_MIN;
				end
				1: begin
					lo = '1;
					hi = '0;
					xf = S_MIN;
					bf = S_MAX;
				end
				2: begin
					lo = '0;
					hi = '0;
					xf = rand_gain();
					bf = rand_gain();
				end
				default: begin
					lo = {8'($urandom), $urandom};
					hi = {8'($urandom), $urandom};
					xf = rand_gain();
					bf = rand_gain();
				end
			endcase
			program_curve(lo, hi, xf, bf);
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				if (n % 25 == 0) begin
					burst = ($urandom_range(0, 2) == 0);
				end
				queue_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample(), burst ? 0 : $urandom_range(0, 16));
			end
			await_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
